// ===== rtl/sha_pkg.sv =====
// SHA-256 package: round constants, initial hash values and a rotate-right helper.
// No dependencies.
`default_nettype none
package sha_pkg;
   typedef logic [31:0] word_type;

   localparam logic [31:0] PAD_WORD = 32'h8000_0000;

   function automatic word_type init_hash(input logic [2:0] i);
      word_type r;
      case (i)
         3'd0: r = 32'h6A09E667;
         3'd1: r = 32'hBB67AE85;
         3'd2: r = 32'h3C6EF372;
         3'd3: r = 32'hA54FF53A;
         3'd4: r = 32'h510E527F;
         3'd5: r = 32'h9B05688C;
         3'd6: r = 32'h1F83D9AB;
         default: r = 32'h5BE0CD19;
      endcase
      return r;
   endfunction

   function automatic word_type round_k(input logic [5:0] i);
      word_type r;
      case (i)
         6'd0: r = 32'h428A2F98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hB5C0FBCF;
         6'd3: r = 32'hE9B5DBA5; 6'd4: r = 32'h3956C25B; 6'd5: r = 32'h59F111F1;
         6'd6: r = 32'h923F82A4; 6'd7: r = 32'hAB1C5ED5; 6'd8: r = 32'hD807AA98;
         6'd9: r = 32'h12835B01; 6'd10: r = 32'h243185BE; 6'd11: r = 32'h550C7DC3;
         6'd12: r = 32'h72BE5D74; 6'd13: r = 32'h80DEB1FE; 6'd14: r = 32'h9BDC06A7;
         6'd15: r = 32'hC19BF174; 6'd16: r = 32'hE49B69C1; 6'd17: r = 32'hEFBE4786;
         6'd18: r = 32'h0FC19DC6; 6'd19: r = 32'h240CA1CC; 6'd20: r = 32'h2DE92C6F;
         6'd21: r = 32'h4A7484AA; 6'd22: r = 32'h5CB0A9DC; 6'd23: r = 32'h76F988DA;
         6'd24: r = 32'h983E5152; 6'd25: r = 32'hA831C66D; 6'd26: r = 32'hB00327C8;
         6'd27: r = 32'hBF597FC7; 6'd28: r = 32'hC6E00BF3; 6'd29: r = 32'hD5A79147;
         6'd30: r = 32'h06CA6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27B70A85;
         6'd33: r = 32'h2E1B2138; 6'd34: r = 32'h4D2C6DFC; 6'd35: r = 32'h53380D13;
         6'd36: r = 32'h650A7354; 6'd37: r = 32'h766A0ABB; 6'd38: r = 32'h81C2C92E;
         6'd39: r = 32'h92722C85; 6'd40: r = 32'hA2BFE8A1; 6'd41: r = 32'hA81A664B;
         6'd42: r = 32'hC24B8B70; 6'd43: r = 32'hC76C51A3; 6'd44: r = 32'hD192E819;
         6'd45: r = 32'hD6990624; 6'd46: r = 32'hF40E3585; 6'd47: r = 32'h106AA070;
         6'd48: r = 32'h19A4C116; 6'd49: r = 32'h1E376C08; 6'd50: r = 32'h2748774C;
         6'd51: r = 32'h34B0BCB5; 6'd52: r = 32'h391C0CB3; 6'd53: r = 32'h4ED8AA4A;
         6'd54: r = 32'h5B9CCA4F; 6'd55: r = 32'h682E6FF3; 6'd56: r = 32'h748F82EE;
         6'd57: r = 32'h78A5636F; 6'd58: r = 32'h84C87814; 6'd59: r = 32'h8CC70208;
         6'd60: r = 32'h90BEFFFA; 6'd61: r = 32'hA4506CEB; 6'd62: r = 32'hBEF9A3F7;
         default: r = 32'hC67178F2;
      endcase
      return r;
   endfunction

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction
endpackage
`default_nettype wire

// ===== rtl/sha256_digest.sv =====
// SHA-256 over a stream of 32-bit words; one shared round unit, one round per cycle.
// Depends on sha_pkg.
// A word is taken in ST_IDLE; a 16th word then runs 64 rounds in ST_ROUND and a fold in ST_FOLD.
// A last word leads to one or two padding compressions (ST_PAD, ST_ROUND, ST_FOLD), then eight
// digest beats. New words are taken only in ST_IDLE, not while a block is compressed or output.
// Reset (synchronous): hash to initial values, fill and length to zero, ready in idle.
`default_nettype none
module sha256_digest (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_data_word,
   input  wire logic [2:0]  req_byte_count,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_digest_last
);
   import sha_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ROUND = 5'b00010,
      ST_FOLD  = 5'b00100,
      ST_PAD   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   word_type    hash_ff [8];
   word_type    w_ff [16];
   word_type    v_ff [8];
   logic [3:0]  idx_ff;
   logic [63:0] len_ff;
   logic [5:0]  rnd_ff;
   logic [2:0]  oidx_ff;
   logic        fin_ff;    // padding still pending after this compression
   logic        mark_ff;   // pad marker still to be placed
   logic        full_ff;   // all 16 slots hold data, compress before going on
   logic        done_ff;   // length block running, digest follows

   logic [2:0]  nb;
   word_type    keep, lastw, t1, t2, e, a, s0w, s1w, wnew;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = hash_ff[oidx_ff];
   assign rsp_word_index  = oidx_ff;
   assign rsp_digest_last = (oidx_ff == 3'd7);

   assign nb = (req_byte_count > 3'd4) ? 3'd4 : req_byte_count;

   always_comb begin
      keep = (nb == 3'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - {nb, 3'b000}));
      lastw = (nb == 3'd4) ? req_data_word :
              ((req_data_word & keep) | (PAD_WORD >> {nb, 3'b000}));
      e = v_ff[4];
      a = v_ff[0];
      t1 = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
         + ((e & v_ff[5]) ^ (~e & v_ff[6])) + round_k(rnd_ff) + w_ff[0];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
         + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      s0w = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1w = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = s1w + w_ff[9] + s0w + w_ff[0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            if (req_last) state_in = ST_PAD;
            else if (idx_ff == 4'd15) state_in = ST_ROUND;
         end
         ST_PAD: if (full_ff || !mark_ff) state_in = ST_ROUND;
         ST_ROUND: if (rnd_ff == 6'd63) state_in = ST_FOLD;
         ST_FOLD: begin
            if (fin_ff) state_in = ST_PAD;
            else if (done_ff) state_in = ST_OUT;
            else state_in = ST_IDLE;
         end
         ST_OUT: if (rsp_ready && oidx_ff == 3'd7) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < 8; i++) hash_ff[i] <= init_hash(3'(i));
         idx_ff <= '0; len_ff <= '0; rnd_ff <= '0; oidx_ff <= '0;
         fin_ff <= 1'b0; mark_ff <= 1'b0; full_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: if (req_valid) begin
               len_ff <= len_ff + (req_last ? {58'd0, nb, 3'b000} : 64'd32);
               w_ff[idx_ff] <= req_last ? lastw : req_data_word;
               idx_ff <= idx_ff + 4'd1;
               if (req_last) begin
                  fin_ff <= 1'b1;
                  mark_ff <= (nb == 3'd4);
                  full_ff <= (idx_ff == 4'd15);
               end else if (idx_ff == 4'd15) begin
                  rnd_ff <= '0;
                  for (int i = 0; i < 8; i++) v_ff[i] <= hash_ff[i];
               end
            end
            ST_PAD: begin
               if (full_ff) begin
                  full_ff <= 1'b0;
               end else if (mark_ff) begin
                  w_ff[idx_ff] <= PAD_WORD;
                  mark_ff <= 1'b0;
                  idx_ff <= idx_ff + 4'd1;
                  full_ff <= (idx_ff == 4'd15);
               end else if (idx_ff == 4'd15) begin
                  // no room for the length: zero the tail and compress
                  w_ff[15] <= '0;
                  idx_ff <= '0;
               end else begin
                  for (int k = 0; k < 14; k++)
                     if (4'(k) >= idx_ff) w_ff[k] <= '0;
                  w_ff[14] <= len_ff[63:32];
                  w_ff[15] <= len_ff[31:0];
                  fin_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
               if (full_ff || !mark_ff) begin
                  for (int i = 0; i < 8; i++) v_ff[i] <= hash_ff[i];
                  rnd_ff <= '0;
               end
            end
            ST_ROUND: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= wnew;
               v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               rnd_ff <= rnd_ff + 6'd1;
            end
            ST_FOLD: begin
               for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + v_ff[i];
               if (!fin_ff && done_ff) begin
                  done_ff <= 1'b0;
                  oidx_ff <= '0;
               end
            end
            ST_OUT: if (rsp_ready) begin
               oidx_ff <= oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) hash_ff[i] <= init_hash(3'(i));
                  idx_ff <= '0; len_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire
